// ===== hdl/mfl_pkg.sv =====
// Shared types for the max-flow level-graph block: item words, datapath
// command codes and datapath status flags. No dependencies.
`timescale 1ns / 1ps

package mfl_pkg;

    typedef struct packed {
        logic        action;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] capacity;
    } t_in;

    typedef struct packed {
        logic [24:0] max_flow;
        logic [1:0]  status;
    } t_out;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_DECODE,
        OP_ADD1,
        OP_ADD2,
        OP_ADD3,
        OP_ADD4,
        OP_BFS_INIT,
        OP_BFS_POP,
        OP_BFS_U,
        OP_BFS_HEAD,
        OP_BFS_ARC,
        OP_AUG_INIT,
        OP_AUG_NODE,
        OP_AUG_CUR,
        OP_SCAN_A,
        OP_SCAN_B,
        OP_RETREAT,
        OP_RET_B,
        OP_RET_C,
        OP_MIN_A,
        OP_MIN_B,
        OP_MIN_C,
        OP_AP_A,
        OP_AP_B,
        OP_AP_C,
        OP_AP_D,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic is_run;
        logic add_bad;
        logic src_eq_sink;
        logic run_bad;
        logic q_empty;
        logic q_sink;
        logic u_sink;
        logic has_list;
        logic next_none;
        logic nx_none;
        logic cur_none;
        logic arc_ok;
        logic depth_zero;
        logic k_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/max_flow_level_graph.sv =====
// Top level of the max-flow block: sequencer plus datapath.
// Depends on mfl_pkg, mfl_ctrl, mfl_dp (and mfl_ram through mfl_dp).
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+------------------
//   in      | input     | i_in_valid / o_in_ready    | mfl_pkg::t_in
//   out     | output    | o_out_valid / i_out_ready  | mfl_pkg::t_out
//   cfg     | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// An edge load steps through accept, decode and four RAM write steps.
// A run's length depends on the data and on the one read port of each arc RAM:
// each level pass pops the queued nodes and walks their arcs, the search scans arcs
// and retreats, and each augmentation takes the minimum over the path arcs, then applies it.
// Reset clears list, level and pointer valid bits at once; no clearing pass.
// A result waits in the output register while the next word is accepted.
`timescale 1ns / 1ps

module max_flow_level_graph #(
    parameter int MAX_NODES     = 64,
    parameter int MAX_ARCS      = 1024,
    parameter int CAPACITY_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mfl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mfl_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [6:0]    i_cfg_data
);

    mfl_pkg::t_op      op;
    mfl_pkg::t_dp_stat stat;

    mfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_op       (op)
    );

    mfl_dp #(
        .MAX_NODES     (MAX_NODES),
        .MAX_ARCS      (MAX_ARCS),
        .CAPACITY_BITS (CAPACITY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_stat      (stat)
    );

endmodule

// ===== hdl/mfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mfl_ctrl.sv =====
// Sequencer for the max-flow block: walks edge loads, level passes and
// augmentations. Depends on mfl_pkg for command codes and status flags.
`timescale 1ns / 1ps

module mfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mfl_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output mfl_pkg::t_op      o_op
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_ADD1, S_ADD2, S_ADD3, S_ADD4,
        S_BFS_INIT, S_BFS_POP, S_BFS_U, S_BFS_HEAD, S_BFS_ARC,
        S_AUG_INIT, S_AUG_NODE, S_AUG_CUR, S_SCAN_A, S_SCAN_B,
        S_RETREAT, S_RET_B, S_RET_C,
        S_MIN_A, S_MIN_B, S_MIN_C,
        S_AP_A, S_AP_B, S_AP_C, S_AP_D,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (!i_stat.is_run) begin
                    n_state = i_stat.add_bad ? S_EMIT : S_ADD1;
                end else begin
                    n_state = (i_stat.src_eq_sink || i_stat.run_bad) ? S_EMIT : S_BFS_INIT;
                end
            end
            S_ADD1:     n_state = S_ADD2;
            S_ADD2:     n_state = S_ADD3;
            S_ADD3:     n_state = S_ADD4;
            S_ADD4:     n_state = S_IDLE;
            S_BFS_INIT: n_state = S_BFS_POP;
            S_BFS_POP:  n_state = i_stat.q_empty ? S_EMIT : S_BFS_U;
            S_BFS_U:    n_state = i_stat.q_sink ? S_AUG_INIT : S_BFS_HEAD;
            S_BFS_HEAD: n_state = i_stat.has_list ? S_BFS_ARC : S_BFS_POP;
            S_BFS_ARC:  n_state = i_stat.next_none ? S_BFS_POP : S_BFS_ARC;
            S_AUG_INIT: n_state = S_AUG_NODE;
            S_AUG_NODE: n_state = i_stat.u_sink ? S_MIN_A : S_AUG_CUR;
            S_AUG_CUR:  n_state = i_stat.cur_none ? S_RETREAT : S_SCAN_A;
            S_SCAN_A:   n_state = S_SCAN_B;
            S_SCAN_B: begin
                if (i_stat.arc_ok) begin
                    n_state = S_AUG_NODE;
                end else begin
                    n_state = i_stat.nx_none ? S_RETREAT : S_SCAN_A;
                end
            end
            S_RETREAT:  n_state = i_stat.depth_zero ? S_BFS_INIT : S_RET_B;
            S_RET_B:    n_state = S_RET_C;
            S_RET_C:    n_state = S_AUG_NODE;
            S_MIN_A:    n_state = i_stat.k_done ? S_AP_A : S_MIN_B;
            S_MIN_B:    n_state = S_MIN_C;
            S_MIN_C:    n_state = S_MIN_A;
            S_AP_A:     n_state = i_stat.k_done ? S_AUG_INIT : S_AP_B;
            S_AP_B:     n_state = S_AP_C;
            S_AP_C:     n_state = S_AP_D;
            S_AP_D:     n_state = S_AP_A;
            S_EMIT:     n_state = i_stat.out_free ? S_IDLE : S_EMIT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:     o_op = mfl_pkg::OP_IDLE;
            S_DECODE:   o_op = mfl_pkg::OP_DECODE;
            S_ADD1:     o_op = mfl_pkg::OP_ADD1;
            S_ADD2:     o_op = mfl_pkg::OP_ADD2;
            S_ADD3:     o_op = mfl_pkg::OP_ADD3;
            S_ADD4:     o_op = mfl_pkg::OP_ADD4;
            S_BFS_INIT: o_op = mfl_pkg::OP_BFS_INIT;
            S_BFS_POP:  o_op = mfl_pkg::OP_BFS_POP;
            S_BFS_U:    o_op = mfl_pkg::OP_BFS_U;
            S_BFS_HEAD: o_op = mfl_pkg::OP_BFS_HEAD;
            S_BFS_ARC:  o_op = mfl_pkg::OP_BFS_ARC;
            S_AUG_INIT: o_op = mfl_pkg::OP_AUG_INIT;
            S_AUG_NODE: o_op = mfl_pkg::OP_AUG_NODE;
            S_AUG_CUR:  o_op = mfl_pkg::OP_AUG_CUR;
            S_SCAN_A:   o_op = mfl_pkg::OP_SCAN_A;
            S_SCAN_B:   o_op = mfl_pkg::OP_SCAN_B;
            S_RETREAT:  o_op = mfl_pkg::OP_RETREAT;
            S_RET_B:    o_op = mfl_pkg::OP_RET_B;
            S_RET_C:    o_op = mfl_pkg::OP_RET_C;
            S_MIN_A:    o_op = mfl_pkg::OP_MIN_A;
            S_MIN_B:    o_op = mfl_pkg::OP_MIN_B;
            S_MIN_C:    o_op = mfl_pkg::OP_MIN_C;
            S_AP_A:     o_op = mfl_pkg::OP_AP_A;
            S_AP_B:     o_op = mfl_pkg::OP_AP_B;
            S_AP_C:     o_op = mfl_pkg::OP_AP_C;
            S_AP_D:     o_op = mfl_pkg::OP_AP_D;
            S_EMIT:     o_op = mfl_pkg::OP_EMIT;
            default:    o_op = mfl_pkg::OP_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/mfl_dp.sv =====
// Datapath of the max-flow block: arc table, node lists, levels, current-arc
// pointers, search queue and path stack in RAMs, plus the output register.
// Depends on mfl_pkg and mfl_ram.
`timescale 1ns / 1ps

module mfl_dp #(
    parameter int MAX_NODES     = 64,
    parameter int MAX_ARCS      = 1024,
    parameter int CAPACITY_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mfl_pkg::t_op      i_op,
    input  mfl_pkg::t_in      i_in_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [6:0]        i_cfg_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output mfl_pkg::t_out     o_out_data,
    output mfl_pkg::t_dp_stat o_stat
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int AW  = $clog2(MAX_ARCS);
    localparam int PW  = $clog2(MAX_ARCS + 1);
    localparam int CW  = CAPACITY_BITS;
    localparam int LW  = NCW;

    localparam logic [PW-1:0] NO_ARC = PW'(MAX_ARCS);

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOURCE     = 2'd1;
    localparam logic [1:0] CFG_SINK       = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAME = 2'd2;

    // configuration and control state
    logic [6:0]           r_node_count;
    logic [5:0]           r_src;
    logic [5:0]           r_sink;
    logic [PW-1:0]        r_arc_count;
    logic [MAX_NODES-1:0] r_nonempty;
    logic [MAX_NODES-1:0] r_lvl_v;
    logic [MAX_NODES-1:0] r_cur_v;
    logic                 r_out_valid;

    // working registers
    mfl_pkg::t_in  r_in;
    mfl_pkg::t_out r_out;
    logic [NCW-1:0] r_qh;
    logic [NCW-1:0] r_qt;
    logic [NW-1:0]  r_u;
    logic           r_has;
    logic           r_curv;
    logic [LW-1:0]  r_lvl;
    logic [PW-1:0]  r_a;
    logic [NW-1:0]  r_v;
    logic [PW-1:0]  r_nx;
    logic           r_fok;
    logic [NW-1:0]  r_depth;
    logic [NW-1:0]  r_k;
    logic [AW-1:0]  r_e;
    logic [CW-1:0]  r_push;
    logic [24:0]    r_run;
    logic [1:0]     r_status;

    // RAM ports
    logic          dest_we, cap_we, flow_we, next_we;
    logic [AW-1:0] dest_wa, cap_wa, flow_wa, next_wa;
    logic [NW-1:0] dest_wd;
    logic [CW-1:0] cap_wd;
    logic [CW:0]   flow_wd;
    logic [PW-1:0] next_wd;
    logic [AW-1:0] arc_ra, dest_ra;
    logic [NW-1:0] dest_rd;
    logic [CW-1:0] cap_rd;
    logic [CW:0]   flow_rd;
    logic [PW-1:0] next_rd;

    logic          head_we, tail_we, lvl_we, cur_we, q_we, st_we;
    logic [NW-1:0] head_wa, tail_wa, lvl_wa, cur_wa, q_wa, st_wa;
    logic [PW-1:0] head_wd, tail_wd, cur_wd;
    logic [LW-1:0] lvl_wd;
    logic [NW-1:0] q_wd;
    logic [AW-1:0] st_wd;
    logic [NW-1:0] node_ra, tail_ra, q_ra, st_ra;
    logic [PW-1:0] head_rd, tail_rd, cur_rd;
    logic [LW-1:0] lvl_rd;
    logic [NW-1:0] q_rd;
    logic [AW-1:0] st_rd;

    // derived values
    logic [NCW-1:0] nc;
    logic [NW-1:0]  src_n, sink_n, from_n, to_n;
    logic [AW-1:0]  a0, a1;
    logic [CW-1:0]  cap_in;
    logic [PW-1:0]  a_sel;
    logic           flow_lt;
    logic           bfs_take;
    logic           scan_ok;
    logic [CW:0]    resid_full;
    logic [CW-1:0]  resid;
    logic [CW-1:0]  new_push;
    logic           out_free;

    assign nc = (32'(r_node_count) > 32'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(r_node_count);
    assign src_n  = NW'(r_src);
    assign sink_n = NW'(r_sink);
    assign from_n = NW'(r_in.from_node);
    assign to_n   = NW'(r_in.to_node);
    assign a0     = AW'(r_arc_count);
    assign a1     = a0 + AW'(1);
    assign cap_in = CW'(r_in.capacity);

    assign a_sel    = r_curv ? cur_rd : (r_has ? head_rd : NO_ARC);
    assign flow_lt  = $signed(flow_rd) < $signed({1'b0, cap_rd});
    assign bfs_take = flow_lt && (32'(dest_rd) < 32'(nc)) && !r_lvl_v[dest_rd];
    assign scan_ok  = r_lvl_v[r_v] && (lvl_rd == r_lvl + LW'(1)) && r_fok;
    assign resid_full = {1'b0, cap_rd} - flow_rd;
    assign resid      = resid_full[CW-1:0];
    assign new_push   = ((r_k == '0) || (resid < r_push)) ? resid : r_push;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.is_run      = r_in.action;
        o_stat.add_bad     = (32'(r_in.from_node) >= 32'(MAX_NODES))
                          || (32'(r_in.to_node) >= 32'(MAX_NODES))
                          || (32'(r_arc_count) + 32'd2 > 32'(MAX_ARCS));
        o_stat.src_eq_sink = (r_src == r_sink);
        o_stat.run_bad     = (32'(r_src) >= 32'(nc)) || (32'(r_sink) >= 32'(nc));
        o_stat.q_empty     = (r_qh == r_qt);
        o_stat.q_sink      = (q_rd == sink_n);
        o_stat.u_sink      = (r_u == sink_n);
        o_stat.has_list    = r_has;
        o_stat.next_none   = (next_rd == NO_ARC);
        o_stat.nx_none     = (r_nx == NO_ARC);
        o_stat.cur_none    = (a_sel == NO_ARC);
        o_stat.arc_ok      = scan_ok;
        o_stat.depth_zero  = (r_depth == '0);
        o_stat.k_done      = (r_k == r_depth);
        o_stat.out_free    = out_free;
    end

    // RAM addresses and writes for each command
    always_comb begin
        dest_we = 1'b0; dest_wa = a0; dest_wd = to_n;
        cap_we  = 1'b0; cap_wa  = a0; cap_wd  = cap_in;
        flow_we = 1'b0; flow_wa = a0; flow_wd = '0;
        next_we = 1'b0; next_wa = a0; next_wd = NO_ARC;
        head_we = 1'b0; head_wa = from_n; head_wd = PW'(a0);
        tail_we = 1'b0; tail_wa = from_n; tail_wd = PW'(a0);
        lvl_we  = 1'b0; lvl_wa  = src_n;  lvl_wd  = '0;
        cur_we  = 1'b0; cur_wa  = r_u;    cur_wd  = a_sel;
        q_we    = 1'b0; q_wa    = '0;     q_wd    = src_n;
        st_we   = 1'b0; st_wa   = r_depth; st_wd  = r_a[AW-1:0];
        arc_ra  = r_e;
        node_ra = r_u;
        tail_ra = (i_op == mfl_pkg::OP_ADD3) ? to_n : from_n;
        q_ra    = r_qh[NW-1:0];
        st_ra   = (i_op == mfl_pkg::OP_RETREAT) ? (r_depth - NW'(1)) : r_k;
        case (i_op)
            mfl_pkg::OP_ADD1: begin
                dest_we = 1'b1;
                cap_we  = 1'b1;
                flow_we = 1'b1;
                next_we = 1'b1;
                head_we = !r_nonempty[from_n];
            end
            mfl_pkg::OP_ADD2: begin
                next_we = r_nonempty[from_n];
                next_wa = tail_rd[AW-1:0];
                next_wd = PW'(a0);
                tail_we = 1'b1;
            end
            mfl_pkg::OP_ADD3: begin
                dest_we = 1'b1; dest_wa = a1; dest_wd = from_n;
                cap_we  = 1'b1; cap_wa  = a1; cap_wd  = '0;
                flow_we = 1'b1; flow_wa = a1;
                next_we = 1'b1; next_wa = a1;
                head_we = !r_nonempty[to_n];
                head_wa = to_n;
                head_wd = PW'(a1);
            end
            mfl_pkg::OP_ADD4: begin
                next_we = r_nonempty[to_n];
                next_wa = tail_rd[AW-1:0];
                next_wd = PW'(a1);
                tail_we = 1'b1;
                tail_wa = to_n;
                tail_wd = PW'(a1);
            end
            mfl_pkg::OP_BFS_INIT: begin
                lvl_we = 1'b1;
                q_we   = 1'b1;
            end
            mfl_pkg::OP_BFS_U: begin
                node_ra = q_rd;
            end
            mfl_pkg::OP_BFS_HEAD: begin
                arc_ra = head_rd[AW-1:0];
            end
            mfl_pkg::OP_BFS_ARC: begin
                arc_ra = next_rd[AW-1:0];
                lvl_we = bfs_take;
                lvl_wa = dest_rd;
                lvl_wd = r_lvl + LW'(1);
                q_we   = bfs_take && (r_qt != NCW'(MAX_NODES));
                q_wa   = r_qt[NW-1:0];
                q_wd   = dest_rd;
            end
            mfl_pkg::OP_AUG_CUR: begin
                arc_ra = a_sel[AW-1:0];
                cur_we = 1'b1;
            end
            mfl_pkg::OP_SCAN_A: begin
                node_ra = dest_rd;
            end
            mfl_pkg::OP_SCAN_B: begin
                arc_ra = r_nx[AW-1:0];
                if (scan_ok) begin
                    st_we  = 1'b1;
                    cur_we = 1'b1;
                    cur_wd = r_a;
                end else if (r_nx == NO_ARC) begin
                    cur_we = 1'b1;
                    cur_wd = NO_ARC;
                end
            end
            mfl_pkg::OP_RET_B: begin
                arc_ra = st_rd;
            end
            mfl_pkg::OP_RET_C: begin
                cur_we = 1'b1;
                cur_wa = dest_rd;
                cur_wd = next_rd;
            end
            mfl_pkg::OP_MIN_B, mfl_pkg::OP_AP_B: begin
                arc_ra = st_rd;
            end
            mfl_pkg::OP_AP_C: begin
                arc_ra  = r_e ^ AW'(1);
                flow_we = 1'b1;
                flow_wa = r_e;
                flow_wd = flow_rd + {1'b0, r_push};
            end
            mfl_pkg::OP_AP_D: begin
                flow_we = 1'b1;
                flow_wa = r_e ^ AW'(1);
                flow_wd = flow_rd - {1'b0, r_push};
            end
            default: begin
            end
        endcase
        // the reverse arc's destination is the node a retreat returns to
        dest_ra = (i_op == mfl_pkg::OP_RET_B) ? (st_rd ^ AW'(1)) : arc_ra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 7'd64;
            r_src        <= 6'd0;
            r_sink       <= 6'd1;
            r_arc_count  <= '0;
            r_nonempty   <= '0;
            r_lvl_v      <= '0;
            r_cur_v      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    CFG_SOURCE:     r_src        <= i_cfg_data[5:0];
                    CFG_SINK:       r_sink       <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            if ((i_op == mfl_pkg::OP_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                mfl_pkg::OP_ADD2: r_nonempty[from_n] <= 1'b1;
                mfl_pkg::OP_ADD4: begin
                    r_nonempty[to_n] <= 1'b1;
                    r_arc_count      <= r_arc_count + PW'(2);
                end
                mfl_pkg::OP_BFS_INIT: begin
                    // only the source holds a level at the start of a pass
                    r_lvl_v <= MAX_NODES'(1) << src_n;
                    r_cur_v <= '0;
                end
                mfl_pkg::OP_BFS_ARC: if (bfs_take) r_lvl_v[dest_rd] <= 1'b1;
                mfl_pkg::OP_AUG_CUR, mfl_pkg::OP_SCAN_B: r_cur_v[r_u] <= 1'b1;
                mfl_pkg::OP_RET_C: r_cur_v[dest_rd] <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            mfl_pkg::OP_IDLE: r_in <= i_in_data;
            mfl_pkg::OP_DECODE: begin
                r_run    <= '0;
                r_status <= !r_in.action ? ST_FULL : ((r_src == r_sink) ? ST_SAME : ST_OK);
            end
            mfl_pkg::OP_BFS_INIT: begin
                r_qh <= '0;
                r_qt <= NCW'(1);
            end
            mfl_pkg::OP_BFS_POP: if (r_qh != r_qt) r_qh <= r_qh + NCW'(1);
            mfl_pkg::OP_BFS_U: begin
                r_u   <= q_rd;
                r_has <= r_nonempty[q_rd];
            end
            mfl_pkg::OP_BFS_HEAD: r_lvl <= lvl_rd;
            mfl_pkg::OP_BFS_ARC: begin
                if (bfs_take && (r_qt != NCW'(MAX_NODES))) r_qt <= r_qt + NCW'(1);
            end
            mfl_pkg::OP_AUG_INIT: begin
                r_u     <= src_n;
                r_depth <= '0;
                r_k     <= '0;
            end
            mfl_pkg::OP_AUG_NODE: begin
                r_has  <= r_nonempty[r_u];
                r_curv <= r_cur_v[r_u];
            end
            mfl_pkg::OP_AUG_CUR: begin
                r_lvl <= lvl_rd;
                r_a   <= a_sel;
            end
            mfl_pkg::OP_SCAN_A: begin
                r_v   <= dest_rd;
                r_nx  <= next_rd;
                r_fok <= flow_lt;
            end
            mfl_pkg::OP_SCAN_B: begin
                if (scan_ok) begin
                    r_depth <= r_depth + NW'(1);
                    r_u     <= r_v;
                end else begin
                    r_a <= r_nx;
                end
            end
            mfl_pkg::OP_RETREAT: if (r_depth != '0) r_depth <= r_depth - NW'(1);
            mfl_pkg::OP_RET_C: r_u <= dest_rd;
            mfl_pkg::OP_MIN_A: if (r_k == r_depth) r_k <= '0;
            mfl_pkg::OP_MIN_B, mfl_pkg::OP_AP_B: r_e <= st_rd;
            mfl_pkg::OP_MIN_C: begin
                r_push <= new_push;
                r_k    <= r_k + NW'(1);
            end
            mfl_pkg::OP_AP_A: if (r_k == r_depth) r_run <= r_run + 25'(r_push);
            mfl_pkg::OP_AP_D: r_k <= r_k + NW'(1);
            mfl_pkg::OP_EMIT: begin
                if (out_free) begin
                    r_out.max_flow <= r_run;
                    r_out.status   <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    mfl_ram #(.WIDTH(NW), .DEPTH(MAX_ARCS)) u_arc_dest (
        .i_clk(i_clk), .i_we(dest_we), .i_waddr(dest_wa), .i_wdata(dest_wd),
        .i_raddr(dest_ra), .o_rdata(dest_rd)
    );
    mfl_ram #(.WIDTH(CW), .DEPTH(MAX_ARCS)) u_arc_cap (
        .i_clk(i_clk), .i_we(cap_we), .i_waddr(cap_wa), .i_wdata(cap_wd),
        .i_raddr(arc_ra), .o_rdata(cap_rd)
    );
    mfl_ram #(.WIDTH(CW + 1), .DEPTH(MAX_ARCS)) u_arc_flow (
        .i_clk(i_clk), .i_we(flow_we), .i_waddr(flow_wa), .i_wdata(flow_wd),
        .i_raddr(arc_ra), .o_rdata(flow_rd)
    );
    mfl_ram #(.WIDTH(PW), .DEPTH(MAX_ARCS)) u_arc_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(arc_ra), .o_rdata(next_rd)
    );
    mfl_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_list_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(node_ra), .o_rdata(head_rd)
    );
    mfl_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_list_tail (
        .i_clk(i_clk), .i_we(tail_we), .i_waddr(tail_wa), .i_wdata(tail_wd),
        .i_raddr(tail_ra), .o_rdata(tail_rd)
    );
    mfl_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_node_level (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_wa), .i_wdata(lvl_wd),
        .i_raddr(node_ra), .o_rdata(lvl_rd)
    );
    mfl_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_current_arc (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(cur_wa), .i_wdata(cur_wd),
        .i_raddr(node_ra), .o_rdata(cur_rd)
    );
    mfl_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_search_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(q_ra), .o_rdata(q_rd)
    );
    mfl_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_path_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd)
    );

endmodule

// ===== tb/tb_max_flow_level_graph.sv =====
// Testbench for max_flow_level_graph: a directed table, then random graph loads and
// flow runs, checked against a behavioral Dinic predictor. Depends on mfl_pkg.
`timescale 1ns / 1ps

module tb_max_flow_level_graph;

    localparam int NODE_SLOTS = 64;
    localparam int ARC_SLOTS  = 1024;
    localparam int NO_ARC     = ARC_SLOTS;
    localparam int IDLE_LIMIT = 400000;
    localparam int SETTLE     = 20;

    localparam logic       ACT_ADD   = 1'b0;
    localparam logic       ACT_RUN   = 1'b1;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_SAME   = 2'd2;
    localparam logic [1:0] REG_NODES = 2'd0;
    localparam logic [1:0] REG_SRC   = 2'd1;
    localparam logic [1:0] REG_SINK  = 2'd2;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;
    typedef struct {
        t_row_kind     kind;
        mfl_pkg::t_in  w;
        logic [1:0]    idx;
        logic [6:0]    val;
        bit            chk;
        mfl_pkg::t_out res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    mfl_pkg::t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    mfl_pkg::t_out o_out_data;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [6:0] i_cfg_data;

    max_flow_level_graph dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // graph mirror
    int     arc_to  [ARC_SLOTS];
    longint arc_cap [ARC_SLOTS];
    longint arc_flw [ARC_SLOTS];
    int     arc_nxt [ARC_SLOTS];
    int     head    [NODE_SLOTS];
    int     tail    [NODE_SLOTS];
    int     level   [NODE_SLOTS];
    int     cur     [NODE_SLOTS];
    int     bfs_q   [NODE_SLOTS];
    int     path    [NODE_SLOTS];
    int     n_arcs;
    int     cfg_nodes, cfg_src, cfg_sink;

    mfl_pkg::t_out flow_q[$];
    int     mismatches;
    int     burst_left;
    int     idle_cycles;
    t_row   rows[$];

    function automatic void add_arc(int t, int h, longint c);
        int a;
        a = n_arcs;
        n_arcs++;
        arc_to[a]  = h;
        arc_cap[a] = c;
        arc_flw[a] = 0;
        arc_nxt[a] = NO_ARC;
        if (head[t] == NO_ARC) head[t] = a;
        else arc_nxt[tail[t]] = a;
        tail[t] = a;
    endfunction

    function automatic bit levels_ok(int nc);
        int qh, qt, u, v, a;
        for (int i = 0; i < NODE_SLOTS; i++) begin
            level[i] = -1;
            cur[i]   = head[i];
        end
        level[cfg_src] = 0;
        bfs_q[0] = cfg_src;
        qh = 0;
        qt = 1;
        while (qh < qt) begin
            u = bfs_q[qh];
            qh++;
            if (u == cfg_sink) return 1;
            a = head[u];
            while (a != NO_ARC) begin
                v = arc_to[a];
                if (arc_flw[a] < arc_cap[a] && v < nc && level[v] == -1) begin
                    level[v] = level[u] + 1;
                    if (qt < NODE_SLOTS) begin
                        bfs_q[qt] = v;
                        qt++;
                    end
                end
                a = arc_nxt[a];
            end
        end
        return level[cfg_sink] != -1;
    endfunction

    function automatic longint push_path();
        int u, depth, a, e;
        longint amt, r;
        u = cfg_src;
        depth = 0;
        forever begin
            if (u == cfg_sink) begin
                amt = -1;
                for (int k = 0; k < depth; k++) begin
                    r = arc_cap[path[k]] - arc_flw[path[k]];
                    if (amt < 0 || r < amt) amt = r;
                end
                if (amt <= 0) return 0;
                for (int k = 0; k < depth; k++) begin
                    arc_flw[path[k]] += amt;
                    arc_flw[path[k] ^ 1] -= amt;
                end
                return amt;
            end
            a = cur[u];
            while (a != NO_ARC) begin
                if (level[u] != -1 && level[arc_to[a]] == level[u] + 1
                    && arc_flw[a] < arc_cap[a]) break;
                a = arc_nxt[a];
            end
            cur[u] = a;
            if (a != NO_ARC) begin
                if (depth >= NODE_SLOTS) return 0;
                path[depth] = a;
                depth++;
                u = arc_to[a];
            end else begin
                if (depth == 0) return 0;
                depth--;
                e = path[depth];
                u = arc_to[e ^ 1];
                if (cur[u] != NO_ARC) cur[u] = arc_nxt[cur[u]];
            end
        end
    endfunction

    // returns 1 when the word yields a result
    function automatic bit predict_flow(input mfl_pkg::t_in w, output mfl_pkg::t_out r);
        int nc;
        longint total, x;
        r = '0;
        if (w.action == ACT_ADD) begin
            if (n_arcs + 2 > ARC_SLOTS) begin
                r.status = ST_FULL;
                return 1;
            end
            add_arc(w.from_node, w.to_node, longint'(w.capacity));
            add_arc(w.to_node, w.from_node, 0);
            return 0;
        end
        if (cfg_src == cfg_sink) begin
            r.status = ST_SAME;
            return 1;
        end
        nc = (cfg_nodes > NODE_SLOTS) ? NODE_SLOTS : cfg_nodes;
        total = 0;
        if (cfg_src < nc && cfg_sink < nc) begin
            while (levels_ok(nc)) begin
                x = push_path();
                while (x > 0) begin
                    total += x;
                    x = push_path();
                end
            end
        end
        r.max_flow = total[24:0];
        r.status   = ST_OK;
        return 1;
    endfunction

    function automatic t_row row_add(int f, int t, int c);
        t_row r;
        r = '{ROW_WORD, '0, '0, '0, 0, '0};
        r.w.action    = ACT_ADD;
        r.w.from_node = 6'(f);
        r.w.to_node   = 6'(t);
        r.w.capacity  = 16'(c);
        return r;
    endfunction

    function automatic t_row row_run(bit chk, logic [1:0] st);
        t_row r;
        r = '{ROW_WORD, '0, '0, '0, chk, '0};
        r.w.action     = ACT_RUN;
        r.res.status   = st;
        return r;
    endfunction

    function automatic t_row row_cfg(logic [1:0] idx, int v);
        t_row r;
        r = '{ROW_CFG, '0, idx, 7'(v), 0, '0};
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // send one word; returns just after the edge that accepts it
    task automatic send_word(input mfl_pkg::t_in w, input bit chk, input mfl_pkg::t_out typed);
        mfl_pkg::t_out r;
        bit   has;
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
            burst_left = $urandom_range(40, 1);
        end
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        has = predict_flow(w, r);
        if (has) flow_q.push_back(chk ? typed : r);
    endtask

    // drop valid, wait for every result, then let an edge load finish
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (flow_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = 7'(v);
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_NODES: cfg_nodes = v;
            REG_SRC:   cfg_src   = v;
            default:   cfg_sink  = v;
        endcase
    endtask

    // receiver stall pattern: the upper tick bits pick one of four modes in turn
    int unsigned rx_tick;
    logic [15:0] rx_mask;
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick[7:0] == 0) rx_mask <= 16'($urandom);
        case (rx_tick[9:8])
            2'd0:    i_out_ready <= 1'b1;
            2'd1:    i_out_ready <= ($urandom_range(1, 0) == 1);
            2'd2:    i_out_ready <= rx_mask[rx_tick[3:0]];
            default: i_out_ready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        mfl_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (flow_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: flow %0d status %0d",
                             o_out_data.max_flow, o_out_data.status);
            end else begin
                want = flow_q.pop_front();
                if (o_out_data.max_flow !== want.max_flow
                    || o_out_data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: flow exp %0d got %0d, status exp %0d got %0d",
                                 want.max_flow, o_out_data.max_flow,
                                 want.status, o_out_data.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("tb_max_flow_level_graph: done, errors");
            $finish;
        end
    end

    initial begin
        mfl_pkg::t_in  w;
        mfl_pkg::t_out none;
        int   span;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_out_ready = 1'b0;
        rx_tick     = 0;
        rx_mask     = '1;
        mismatches  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        none        = '0;
        n_arcs      = 0;
        cfg_nodes   = 64;
        cfg_src     = 0;
        cfg_sink    = 1;
        for (int i = 0; i < NODE_SLOTS; i++) begin
            head[i]  = NO_ARC;
            tail[i]  = NO_ARC;
            level[i] = -1;
            cur[i]   = NO_ARC;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        rows.push_back(row_run(1, ST_OK));
        rows.push_back(row_add(0, 1, 16'hFFFF));
        rows.push_back(row_add(0, 63, 1));
        rows.push_back(row_add(63, 1, 5));
        rows.push_back(row_add(63, 63, 16'hFFFF));
        rows.push_back(row_add(1, 0, 0));
        rows.push_back(row_run(0, ST_OK));
        rows.push_back(row_run(1, ST_OK));
        rows.push_back(row_cfg(REG_SRC, 5));
        rows.push_back(row_cfg(REG_SINK, 5));
        rows.push_back(row_run(1, ST_SAME));
        rows.push_back(row_cfg(REG_SRC, 0));
        rows.push_back(row_cfg(REG_SINK, 63));
        rows.push_back(row_cfg(REG_NODES, 2));
        rows.push_back(row_run(1, ST_OK));
        rows.push_back(row_cfg(REG_NODES, 127));
        rows.push_back(row_add(1, 63, 16'hFFFF));
        rows.push_back(row_run(0, ST_OK));
        rows.push_back(row_add(0, 2, 16'h8000));
        rows.push_back(row_add(2, 63, 16'h7FFF));
        rows.push_back(row_run(0, ST_OK));
        rows.push_back(row_cfg(REG_SINK, 1));
        rows.push_back(row_cfg(REG_NODES, 64));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_word(rows[i].w, rows[i].chk, rows[i].res);
            end
        end

        // random phases, registers changed only while idle
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            span = $urandom_range(64, 4);
            case (ph)
                0: begin
                    write_reg(REG_NODES, 64);
                    write_reg(REG_SRC, 0);
                    write_reg(REG_SINK, 1);
                    span = 8;
                end
                1: begin
                    write_reg(REG_NODES, 2);
                    write_reg(REG_SRC, 1);
                    write_reg(REG_SINK, 0);
                end
                2: begin
                    write_reg(REG_NODES, 127);
                    write_reg(REG_SRC, 63);
                    write_reg(REG_SINK, 0);
                    span = 64;
                end
                3: begin
                    write_reg(REG_SRC, 7);
                    write_reg(REG_SINK, 7);
                end
                default: begin
                    write_reg(REG_NODES, $urandom_range(127, 2));
                    write_reg(REG_SRC, $urandom_range(span - 1, 0));
                    write_reg(REG_SINK, $urandom_range(span - 1, 0));
                end
            endcase
            for (int n = 0; n < 250; n++) begin
                w = '0;
                if ($urandom_range(9, 0) == 0) begin
                    w.action = ACT_RUN;
                    w.from_node = 6'($urandom);
                    w.to_node   = 6'($urandom);
                    w.capacity  = 16'($urandom);
                end else begin
                    w.action = ACT_ADD;
                    if ($urandom_range(7, 0) == 0) begin
                        w.from_node = 6'($urandom_range(63, 0));
                        w.to_node   = 6'($urandom_range(63, 0));
                    end else begin
                        w.from_node = 6'($urandom_range(span - 1, 0));
                        w.to_node   = 6'($urandom_range(span - 1, 0));
                    end
                    case ($urandom_range(5, 0))
                        0:       w.capacity = 16'h0000;
                        1:       w.capacity = 16'hFFFF;
                        2:       w.capacity = 16'($urandom);
                        default: w.capacity = 16'($urandom_range(100, 1));
                    endcase
                end
                send_word(w, 0, none);
            end
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && flow_q.size() == 0)
            $display("tb_max_flow_level_graph: done, clean");
        else
            $display("tb_max_flow_level_graph: done, errors");
        $finish;
    end

endmodule
